// ===== sv/gha_pkg.sv =====
`default_nettype none

package gha_pkg;

	// Sizes
	localparam int SLOT_COUNT = 1024;
	localparam int GEN_W      = 16;
	localparam int IDX_W      = $clog2(SLOT_COUNT);
	localparam int CNT_W      = IDX_W + 1;

	// Field widths on the stream ports
	localparam int OPC_W  = 2;
	localparam int STAT_W = 2;
	localparam int LIM_W  = 11;

	// Opcodes
	localparam logic [OPC_W-1:0] OP_ALLOC    = 2'd0;
	localparam logic [OPC_W-1:0] OP_RELEASE  = 2'd1;
	localparam logic [OPC_W-1:0] OP_VALIDATE = 2'd2;

	// Result status codes
	localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
	localparam logic [STAT_W-1:0] ST_BAD  = 2'd2;

	// Slot table entry: live flag over generation
	typedef struct packed {
		logic             live;
		logic [GEN_W-1:0] gen;
	} slot_entry_t;

	// Free stack entry: index with the generation it will be reissued at
	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [GEN_W-1:0] gen;
	} stack_entry_t;

	localparam int SLOT_ENT_W  = $bits(slot_entry_t);
	localparam int STACK_ENT_W = $bits(stack_entry_t);

	// Controller states
	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

endpackage

`default_nettype wire

// ===== sv/gha_ram.sv =====
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle
module gha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered: data follows in the cycle after the address
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/generational_handle_allocator.sv =====
`default_nettype none

// Channel   Direction  Accept when            Contents
// s_*       in         s_tvalid && s_tready   tuser: opcode; tdata: index, generation
// m_*       out        m_tvalid && m_tready   tuser: status; tdata: index, generation, live
// cfg_*     in         cfg_wen                slots_in_use limit (11 bits)
//
// For each word the slot table and free stack are read on accept (S_IDLE), and
// the result is computed and written back in S_EXEC once the output register is free.
// A finished result sits in the output register; a new word is taken meanwhile,
// and its write-back waits until that result is taken.
// Reset clears counters and state and sets the limit to the table size; no memory
// clearing pass is needed, as slots at or above live plus stacked count are known never handed out.
module generational_handle_allocator
	import gha_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input words
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [9:0] handle_index, [25:10] handle_generation
	input  wire logic [1:0]  s_tuser,   // [1:0] opcode
	// result words
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [39:0] m_tdata,   // [9:0] slot_index, [25:10] slot_generation,
	                                    // [36:26] live_slots
	output logic      [1:0]  m_tuser,   // [1:0] status
	// configuration
	input  wire logic        cfg_wen,
	input  wire logic [10:0] cfg_wdata
);

	state_t state_q, state_d;

	logic [LIM_W-1:0] limit_q;
	logic [CNT_W-1:0] depth_q, live_q;
	logic [OPC_W-1:0] op_q;
	logic [IDX_W-1:0] idx_q;
	logic [GEN_W-1:0] gen_q;

	logic              out_valid_q;
	logic [STAT_W-1:0] out_stat_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic [GEN_W-1:0]  out_gen_q;
	logic [CNT_W-1:0]  out_live_q;

	logic         accept, fire;
	slot_entry_t  slot_rd, slot_wr;
	stack_entry_t stack_rd, stack_wr;
	logic         slot_we, stack_we;
	logic [IDX_W-1:0] slot_waddr, stack_raddr;

	logic [CNT_W-1:0]  limit_sat, used_hw;
	logic              handle_ok;
	logic [STAT_W-1:0] res_stat;
	logic [IDX_W-1:0]  res_idx;
	logic [GEN_W-1:0]  res_gen;
	logic [CNT_W-1:0]  depth_d, live_d;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIM_W'(SLOT_COUNT);
		end else if (cfg_wen) begin
			limit_q <= cfg_wdata;
		end
	end

	// Handshakes
	assign accept = s_tvalid && s_tready;
	assign fire   = (state_q == S_EXEC) && (!out_valid_q || m_tready);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (accept) state_d = S_EXEC;
			S_EXEC:  if (fire) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		case (state_q)
			S_IDLE:  s_tready = 1'b1;
			default: s_tready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Input word capture
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= s_tuser;
			idx_q <= s_tdata[IDX_W-1:0];
			gen_q <= s_tdata[IDX_W +: GEN_W];
		end
	end

	// Memories: both read on accept
	assign stack_raddr = IDX_W'(depth_q - CNT_W'(1));

	gha_ram #(.WIDTH(SLOT_ENT_W), .DEPTH(SLOT_COUNT)) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wr),
		.re    (accept),
		.raddr (s_tdata[IDX_W-1:0]),
		.rdata (slot_rd)
	);

	gha_ram #(.WIDTH(STACK_ENT_W), .DEPTH(SLOT_COUNT)) u_stack_ram (
		.clk   (clk),
		.we    (stack_we),
		.waddr (depth_q[IDX_W-1:0]),
		.wdata (stack_wr),
		.re    (accept),
		.raddr (stack_raddr),
		.rdata (stack_rd)
	);

	// Limit saturates at the table size; slots below used_hw have been written
	assign limit_sat = (limit_q > LIM_W'(SLOT_COUNT)) ? CNT_W'(SLOT_COUNT) : CNT_W'(limit_q);
	assign used_hw   = live_q + depth_q;
	assign handle_ok = ({1'b0, idx_q} < used_hw) && slot_rd.live && (slot_rd.gen == gen_q);

	// Execute: result, write-back and counter updates
	always_comb begin
		res_stat     = ST_BAD;
		res_idx      = idx_q;
		res_gen      = gen_q;
		depth_d      = depth_q;
		live_d       = live_q;
		slot_we      = 1'b0;
		slot_waddr   = idx_q;
		slot_wr.live = 1'b0;
		slot_wr.gen  = slot_rd.gen + GEN_W'(1);
		stack_we     = 1'b0;
		stack_wr.idx = idx_q;
		stack_wr.gen = slot_rd.gen + GEN_W'(1);
		case (op_q)
			OP_ALLOC: begin
				if (depth_q != '0) begin
					res_stat = ST_OK;
					res_idx  = stack_rd.idx;
					res_gen  = stack_rd.gen;
					depth_d  = depth_q - CNT_W'(1);
				end else if (live_q < limit_sat) begin
					res_stat = ST_OK;
					res_idx  = live_q[IDX_W-1:0];
					res_gen  = '0;
				end else begin
					res_stat = ST_FULL;
					res_idx  = '0;
					res_gen  = '0;
				end
				if (res_stat == ST_OK) begin
					slot_we      = fire;
					slot_waddr   = res_idx;
					slot_wr.live = 1'b1;
					slot_wr.gen  = res_gen;
					live_d       = live_q + CNT_W'(1);
				end
			end
			OP_RELEASE: begin
				if (handle_ok) begin
					res_stat = ST_OK;
					slot_we  = fire;
					stack_we = fire;
					depth_d  = depth_q + CNT_W'(1);
					live_d   = live_q - CNT_W'(1);
				end
			end
			OP_VALIDATE: begin
				res_stat = handle_ok ? ST_OK : ST_BAD;
			end
			default: res_stat = ST_BAD;
		endcase
	end

	// Counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			live_q  <= '0;
		end else if (fire) begin
			depth_q <= depth_d;
			live_q  <= live_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_stat_q <= res_stat;
			out_idx_q  <= res_idx;
			out_gen_q  <= res_gen;
			out_live_q <= live_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_stat_q;
	assign m_tdata  = {3'b000, out_live_q, out_gen_q, out_idx_q};

`ifndef NO_ASSERTIONS
	// Live plus stacked slots never exceed the table size
	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		(live_q + depth_q) <= CNT_W'(SLOT_COUNT))
		else $error("live plus stacked slots exceed table size");

	// An accepted word always moves on to execute
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_EXEC))
		else $error("accepted word did not reach execute");

	// A full report leaves the counters untouched
	a_full_nochange: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (res_stat == ST_FULL)) |=> ($stable(live_q) && $stable(depth_q)))
		else $error("full allocate changed state");

	// A successful release moves one slot from live to the stack
	a_release_move: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (op_q == OP_RELEASE) && handle_ok) |=>
		((depth_q == $past(depth_q) + CNT_W'(1)) && (live_q == $past(live_q) - CNT_W'(1))))
		else $error("release counter update wrong");
`endif

endmodule

`default_nettype wire
